[hdl/trrw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrw_pkg: shared types and constants for the token replacer
// Item layouts, request and register codes, controller states, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package trrw_pkg;

    localparam int BYTE_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int PLEN_W      = 4;
    localparam int CNT_W       = 5;
    localparam int LIMIT_W     = 17;
    localparam int MATCH_W     = 16;
    localparam int RND_W       = 16;
    localparam int WIDX_W      = 4;
    localparam int BIDX_W      = 5;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    // Remainder unit: four bits of the random value per step.
    localparam int MOD_DIGIT  = 4;
    localparam int MOD_STEPS  = RND_W / MOD_DIGIT;
    localparam int MOD_STEP_W = 2;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int WORD_SLOTS_DEF  = 16;
    localparam int WORD_BYTES_DEF  = 32;

    typedef enum logic [1:0] {
        REQ_TEXT       = 2'd0,
        REQ_END        = 2'd1,
        REQ_WRITE_BYTE = 2'd2,
        REQ_SET_LENGTH = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_WORD_COUNT     = 2'd2,
        CFG_REPLACE_LIMIT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_LEN,
        S_WORD,
        S_FLUSH,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_req              req_type;
        logic [BYTE_W-1:0] data_byte;
        logic [RND_W-1:0]  random_value;
        logic [WIDX_W-1:0] word_index;
        logic [BIDX_W-1:0] byte_index;
        logic [LEN_W-1:0]  word_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic item_start;
        logic append;
        logic load_byte;
        logic load_len;
        logic pop_emit;
        logic mod_step;
        logic word_start;
        logic word_emit;
        logic word_done;
        logic clear_matches;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hold_empty;
        logic hold_ge_plen;
        logic is_prefix;
        logic may_replace;
        logic mod_done;
        logic word_end;
        logic emit_ok;
        logic finish_ok;
    } t_sts;

endpackage

[hdl/trrw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrw_ctrl: sequencer for the token replacer
// Steps one item at a time through scan, remainder, word and flush phases
// and drives the datapath by command bits.
// ----------------------------------------------------------------------------
module trrw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  trrw_pkg::t_req    i_req,
    output logic              o_in_stall,
    input  trrw_pkg::t_sts    i_sts,
    output trrw_pkg::t_cmd    o_cmd
);

    trrw_pkg::t_state r_state;
    trrw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trrw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != trrw_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            trrw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_start = 1'b1;
                    unique case (i_req)
                        trrw_pkg::REQ_TEXT: begin
                            o_cmd.append = 1'b1;
                            n_state      = trrw_pkg::S_SCAN;
                        end
                        trrw_pkg::REQ_END: begin
                            n_state = trrw_pkg::S_FLUSH;
                        end
                        trrw_pkg::REQ_WRITE_BYTE: begin
                            o_cmd.load_byte = 1'b1;
                        end
                        trrw_pkg::REQ_SET_LENGTH: begin
                            o_cmd.load_len = 1'b1;
                        end
                        default: begin
                            n_state = trrw_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            trrw_pkg::S_SCAN: begin
                if (i_sts.hold_empty) begin
                    n_state = trrw_pkg::S_FINISH;
                end else if (!i_sts.may_replace || !i_sts.is_prefix) begin
                    // pass the front byte on
                    if (i_sts.emit_ok) begin
                        o_cmd.pop_emit = 1'b1;
                    end
                end else if (!i_sts.hold_ge_plen) begin
                    n_state = trrw_pkg::S_FINISH;
                end else if (i_sts.mod_done) begin
                    n_state = trrw_pkg::S_LEN;
                end else begin
                    n_state = trrw_pkg::S_MOD;
                end
            end
            trrw_pkg::S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = trrw_pkg::S_LEN;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            trrw_pkg::S_LEN: begin
                o_cmd.word_start = 1'b1;
                n_state          = trrw_pkg::S_WORD;
            end
            trrw_pkg::S_WORD: begin
                if (i_sts.word_end) begin
                    o_cmd.word_done = 1'b1;
                    n_state         = trrw_pkg::S_SCAN;
                end else if (i_sts.emit_ok) begin
                    o_cmd.word_emit = 1'b1;
                end
            end
            trrw_pkg::S_FLUSH: begin
                if (i_sts.hold_empty) begin
                    o_cmd.clear_matches = 1'b1;
                    n_state             = trrw_pkg::S_FINISH;
                end else if (i_sts.emit_ok) begin
                    o_cmd.pop_emit = 1'b1;
                end
            end
            trrw_pkg::S_FINISH: begin
                if (i_sts.finish_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = trrw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = trrw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/trrw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrw_dp: datapath of the token replacer
// Configuration registers, hold window, match counter, remainder unit,
// word and length stores, and the pending/output byte registers.
// ----------------------------------------------------------------------------
module trrw_dp #(
    parameter int PATTERN_MAX = trrw_pkg::PATTERN_MAX_DEF,
    parameter int WORD_SLOTS  = trrw_pkg::WORD_SLOTS_DEF,
    parameter int WORD_BYTES  = trrw_pkg::WORD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [trrw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trrw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  trrw_pkg::t_in_item               i_in_item,
    input  trrw_pkg::t_cmd                   i_cmd,
    output trrw_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output trrw_pkg::t_out_item              o_out_item
);

    localparam int BW     = trrw_pkg::BYTE_W;
    localparam int HC_W   = $clog2(PATTERN_MAX + 1);
    localparam int SLOT_W = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int IDX_W  = $clog2(WORD_BYTES + 1);
    localparam int DEPTH  = WORD_SLOTS * WORD_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = trrw_pkg::CNT_W;
    localparam int RC_W   = trrw_pkg::RES_CNT_W;
    localparam int MW     = trrw_pkg::MATCH_W;
    localparam int LW     = trrw_pkg::LIMIT_W;
    localparam int STP_W  = trrw_pkg::MOD_STEP_W;
    localparam int DIG    = trrw_pkg::MOD_DIGIT;

    // configuration
    logic [trrw_pkg::PATTERN_W-1:0] r_cfg_pat;
    logic [trrw_pkg::PLEN_W-1:0]    r_cfg_plen;
    logic [CNT_W-1:0]               r_cfg_wcnt;
    logic [LW-1:0]                  r_cfg_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pat   <= '0;
            r_cfg_plen  <= trrw_pkg::PLEN_W'(1);
            r_cfg_wcnt  <= CNT_W'(1);
            r_cfg_limit <= '1;
        end else if (i_cfg_we) begin
            unique case (trrw_pkg::t_cfg_idx'(i_cfg_idx))
                trrw_pkg::CFG_PATTERN_BYTES:  r_cfg_pat   <= i_cfg_data;
                trrw_pkg::CFG_PATTERN_LENGTH: r_cfg_plen  <= i_cfg_data[trrw_pkg::PLEN_W-1:0];
                trrw_pkg::CFG_WORD_COUNT:     r_cfg_wcnt  <= i_cfg_data[CNT_W-1:0];
                trrw_pkg::CFG_REPLACE_LIMIT:  r_cfg_limit <= i_cfg_data[LW-1:0];
                default:                      r_cfg_pat   <= r_cfg_pat;
            endcase
        end
    end

    // effective pattern length and word count
    logic [HC_W-1:0]  plen;
    logic [CNT_W-1:0] wcnt;

    always_comb begin
        if (r_cfg_plen == '0) begin
            plen = HC_W'(1);
        end else if (32'(r_cfg_plen) > PATTERN_MAX) begin
            plen = HC_W'(PATTERN_MAX);
        end else begin
            plen = HC_W'(r_cfg_plen);
        end
        if (r_cfg_wcnt == '0) begin
            wcnt = CNT_W'(1);
        end else if (32'(r_cfg_wcnt) > WORD_SLOTS) begin
            wcnt = CNT_W'(WORD_SLOTS);
        end else begin
            wcnt = r_cfg_wcnt;
        end
    end

    // hold window
    logic [BW-1:0]   r_win [PATTERN_MAX];
    logic [BW-1:0]   n_win [PATTERN_MAX];
    logic [HC_W-1:0] r_hold;
    logic [HC_W-1:0] n_hold;
    logic            is_prefix;

    always_comb begin
        n_win  = r_win;
        n_hold = r_hold;
        if (i_cmd.append) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (HC_W'(i) == r_hold) begin
                    n_win[i] = i_in_item.data_byte;
                end
            end
            n_hold = r_hold + HC_W'(1);
        end else if (i_cmd.pop_emit) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_hold = r_hold - HC_W'(1);
        end else if (i_cmd.word_done) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                for (int j = i + 1; j < PATTERN_MAX; j++) begin
                    if (HC_W'(j - i) == plen) begin
                        n_win[i] = r_win[j];
                    end
                end
            end
            n_hold = r_hold - plen;
        end
    end

    always_comb begin
        is_prefix = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (HC_W'(i) < r_hold && HC_W'(i) < plen && r_win[i] != r_cfg_pat[BW*i +: BW]) begin
                is_prefix = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else begin
            r_hold <= n_hold;
        end
    end

    // match counter, saturating
    logic [MW-1:0] r_matches;
    logic          may_replace;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matches <= '0;
        end else if (i_cmd.clear_matches) begin
            r_matches <= '0;
        end else if (i_cmd.word_done && r_matches != '1) begin
            r_matches <= r_matches + MW'(1);
        end
    end

    assign may_replace = r_cfg_limit[LW-1] || (r_matches < r_cfg_limit[MW-1:0]);

    // remainder unit: random value mod word count, one digit a step
    logic [trrw_pkg::RND_W-1:0] r_rnd;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W-1:0]           n_rem;
    logic [CNT_W:0]             mod_t;
    logic [STP_W-1:0]           r_mod_step;
    logic                       r_mod_done;
    logic [DIG-1:0]             mod_dig;

    assign mod_dig = r_rnd[trrw_pkg::RND_W-1 -: DIG];

    always_comb begin
        n_rem = r_rem;
        mod_t = '0;
        for (int b = DIG - 1; b >= 0; b--) begin
            mod_t = {n_rem, mod_dig[b]};
            if (mod_t >= {1'b0, wcnt}) begin
                mod_t = mod_t - {1'b0, wcnt};
            end
            n_rem = mod_t[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_start) begin
            r_rnd      <= i_in_item.random_value;
            r_rem      <= '0;
            r_mod_step <= '0;
        end else if (i_cmd.mod_step) begin
            r_rnd      <= r_rnd << DIG;
            r_rem      <= n_rem;
            r_mod_step <= r_mod_step + STP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_done <= 1'b0;
        end else if (i_cmd.item_start) begin
            r_mod_done <= 1'b0;
        end else if (i_cmd.mod_step && r_mod_step == STP_W'(trrw_pkg::MOD_STEPS - 1)) begin
            r_mod_done <= 1'b1;
        end
    end

    logic [SLOT_W-1:0] word_sel;
    assign word_sel = SLOT_W'(r_rem);

    // length store with valid bits
    logic                       len_wr_ok;
    logic [SLOT_W-1:0]          len_wr_slot;
    logic [trrw_pkg::LEN_W-1:0] r_len_mem [WORD_SLOTS];
    logic [WORD_SLOTS-1:0]      r_len_vld;
    logic [trrw_pkg::LEN_W-1:0] r_len_q;
    logic                       r_len_vq;
    logic [trrw_pkg::LEN_W-1:0] len_raw;
    logic [IDX_W-1:0]           len_eff;

    assign len_wr_ok   = i_cmd.load_len && (32'(i_in_item.word_index) < WORD_SLOTS);
    assign len_wr_slot = SLOT_W'(i_in_item.word_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
        end else if (len_wr_ok) begin
            r_len_vld[len_wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_wr_ok) begin
            r_len_mem[len_wr_slot] <= i_in_item.word_length;
        end
        r_len_q  <= r_len_mem[word_sel];
        r_len_vq <= r_len_vld[word_sel];
    end

    always_comb begin
        len_raw = r_len_vq ? r_len_q : '0;
        if (32'(len_raw) > WORD_BYTES) begin
            len_eff = IDX_W'(WORD_BYTES);
        end else begin
            len_eff = IDX_W'(len_raw);
        end
    end

    // word byte store
    logic              byte_wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [BW-1:0]     r_word_mem [DEPTH];
    logic [BW-1:0]     r_rd_byte;

    assign byte_wr_ok = i_cmd.load_byte && (32'(i_in_item.word_index) < WORD_SLOTS)
                        && (32'(i_in_item.byte_index) < WORD_BYTES);
    assign wr_addr = ADDR_W'(32'(i_in_item.word_index) * WORD_BYTES
                             + 32'(i_in_item.byte_index));

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.word_start) begin
            n_idx = '0;
        end else if (i_cmd.word_emit) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // read one byte ahead so the current index always has its data
    assign rd_addr = ADDR_W'(32'(word_sel) * WORD_BYTES + 32'(n_idx));

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (byte_wr_ok) begin
            r_word_mem[wr_addr] <= i_in_item.data_byte;
        end
        r_rd_byte <= r_word_mem[rd_addr];
    end

    // pending byte and output register; the pending byte gets its
    // last flag once the item is known to produce nothing more
    logic            r_out_vld;
    trrw_pkg::t_out_item r_out_item;
    logic            r_pend_vld;
    logic [BW-1:0]   r_pend_byte;
    logic [RC_W-1:0] r_res_cnt;
    logic            cnt_full;
    logic            out_free;
    logic            out_take;
    logic            push_do;
    logic [BW-1:0]   push_byte;
    logic            fin_do;

    assign cnt_full  = (r_res_cnt == RC_W'(trrw_pkg::MAX_RESULTS));
    assign out_take  = r_out_vld && !i_out_stall;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign push_do   = (i_cmd.pop_emit || i_cmd.word_emit) && !cnt_full;
    assign push_byte = i_cmd.word_emit ? r_rd_byte : r_win[0];
    assign fin_do    = i_cmd.finish && r_pend_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_res_cnt  <= '0;
        end else begin
            if (i_cmd.item_start) begin
                r_res_cnt <= '0;
            end else if (push_do) begin
                r_res_cnt <= r_res_cnt + RC_W'(1);
            end
            if (push_do) begin
                r_pend_vld <= 1'b1;
                if (r_pend_vld) begin
                    r_out_vld <= 1'b1;
                end else if (out_take) begin
                    r_out_vld <= 1'b0;
                end
            end else if (fin_do) begin
                r_pend_vld <= 1'b0;
                r_out_vld  <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_do) begin
            r_pend_byte <= push_byte;
            if (r_pend_vld) begin
                r_out_item.out_byte    <= r_pend_byte;
                r_out_item.last_of_run <= 1'b0;
            end
        end else if (fin_do) begin
            r_out_item.out_byte    <= r_pend_byte;
            r_out_item.last_of_run <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_sts              = '0;
        o_sts.hold_empty   = (r_hold == '0);
        o_sts.hold_ge_plen = (r_hold >= plen);
        o_sts.is_prefix    = is_prefix;
        o_sts.may_replace  = may_replace;
        o_sts.mod_done     = r_mod_done;
        o_sts.word_end     = (r_idx == len_eff);
        o_sts.emit_ok      = cnt_full || !r_pend_vld || out_free;
        o_sts.finish_ok    = !r_pend_vld || out_free;
    end

`ifndef SYNTHESIS
    a_res_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= RC_W'(trrw_pkg::MAX_RESULTS))
        else $error("result count ran past its limit");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_do |-> (!r_pend_vld || out_free))
        else $error("byte pushed while output register blocked");

    a_finish_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_pend_vld || out_free))
        else $error("finish issued while output register blocked");

    a_word_after_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.word_emit |-> r_mod_done)
        else $error("word byte emitted before word index was ready");

    a_window_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_hold < HC_W'(PATTERN_MAX)))
        else $error("append into a full hold window");
`endif

endmodule

[hdl/token_replace_random_word_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_replace_random_word_top: streaming token replacer
// Replaces leftmost, non-overlapping occurrences of a configured token, up to
// the replace limit, in a byte stream with a word picked from a loaded table.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall| o_out_item (t_out_item)
//  config   | in        | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
//  Sequencing: one item at a time. For each match the word-index remainder
//  (first match of the item only) and the length read come first; the word
//  bytes are then read one per cycle from the word store, unless the output
//  path is blocked. End of text passes on every held byte.
//  Reset: synchronous, active low; clears the hold window count, the match
//  counter and the word length valid bits; the config registers get defaults.
//  Stalls: a stalled output holds the output register; the sequencer waits
//  while the pending byte is occupied and the output register is held.
//
module token_replace_random_word_top #(
    parameter int PATTERN_MAX = trrw_pkg::PATTERN_MAX_DEF,
    parameter int WORD_SLOTS  = trrw_pkg::WORD_SLOTS_DEF,
    parameter int WORD_BYTES  = trrw_pkg::WORD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  trrw_pkg::t_in_item               i_in_item,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output trrw_pkg::t_out_item              o_out_item,
    // register writes
    input  logic                             i_cfg_we,
    input  logic [trrw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trrw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // command and status between the sequencer and the datapath
    trrw_pkg::t_cmd cmd;
    trrw_pkg::t_sts sts;

    // Sequencer: accept an item only when idle, then walk the window:
    // pass on bytes that cannot start a match, expand complete matches
    // into a table word, and close the item with the last flag.
    trrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req      (i_in_item.req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: window, counters, remainder unit, word stores, and the
    // pending byte that lets the final result carry its last flag.
    trrw_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .WORD_SLOTS  (WORD_SLOTS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
